// ----- hw/rtl/xor_checked_frame_decoder_assert.svh -----
// assertion macros shared by the frame decoder modules
`ifndef XOR_CHECKED_FRAME_DECODER_ASSERT_SVH
`define XOR_CHECKED_FRAME_DECODER_ASSERT_SVH

`ifndef ASSERT_OFF

// same-cycle implication, checked out of reset
`define XCFD_ASSERT_IMP(label_, clk_, rstn_, ante_, cons_) \
  label_: assert property (@(posedge clk_) disable iff (!rstn_) (ante_) |-> (cons_)) \
    else $error("xcfd assertion failed");

// next-cycle implication, checked out of reset
`define XCFD_ASSERT_NXT(label_, clk_, rstn_, ante_, cons_) \
  label_: assert property (@(posedge clk_) disable iff (!rstn_) (ante_) |=> (cons_)) \
    else $error("xcfd assertion failed");

`else

`define XCFD_ASSERT_IMP(label_, clk_, rstn_, ante_, cons_)
`define XCFD_ASSERT_NXT(label_, clk_, rstn_, ante_, cons_)

`endif

`endif

// ----- hw/rtl/xcfd_pkg.sv -----
package xcfd_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned CmdW    = 16;
  localparam int unsigned PosW    = 9;
  localparam int unsigned CfgIdxW = 8;

  typedef logic [ByteW-1:0]   byte_t;
  typedef logic [CmdW-1:0]    cmd_t;
  typedef logic [PosW-1:0]    pos_t;
  typedef logic [CfgIdxW-1:0] cfg_idx_t;

  // configuration register indexes
  localparam cfg_idx_t CfgStartMarker = cfg_idx_t'(0);
  localparam cfg_idx_t CfgMaxPayload  = cfg_idx_t'(1);

  localparam byte_t StartMarkerRst = 8'hAA;
  localparam byte_t MaxPayloadRst  = 8'h40;

  // byte positions inside a frame
  localparam pos_t PosStart   = pos_t'(0);
  localparam pos_t PosLength  = pos_t'(1);
  localparam pos_t PosCmdHi   = pos_t'(2);
  localparam pos_t PosCmdLo   = pos_t'(3);
  localparam pos_t PosPayload = pos_t'(4);
  // highest position reachable: after the checksum of a maximum-length frame
  localparam pos_t PosMax     = pos_t'(4 + 255 + 1);

  typedef enum logic {
    KindPayload = 1'b0,
    KindStatus  = 1'b1
  } kind_e;

  typedef struct packed {
    byte_t start_marker;
    byte_t max_payload;
  } cfg_t;

  typedef struct packed {
    kind_e kind;
    cmd_t  command;
    byte_t payload_byte;
    byte_t byte_index;
    logic  bad_start;
    logic  bad_length;
    logic  bad_checksum;
    logic  frame_invalid;
  } res_t;

endpackage

// ----- hw/rtl/xcfd_parser.sv -----
`include "xor_checked_frame_decoder_assert.svh"

module xcfd_parser
  import xcfd_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  step_i,
  input  byte_t byte_i,
  input  logic  first_i,
  input  cfg_t  cfg_i,
  output logic  res_valid_o,
  output res_t  res_o
);

  pos_t       pos_q, pos_d;
  byte_t      xor_q, xor_d;
  byte_t      len_q, len_d;
  cmd_t       cmd_q, cmd_d;
  logic [1:0] err_q, err_d;

  pos_t pos_eff;
  pos_t pos_end;
  logic bad_sum;

  assign pos_eff = first_i ? PosStart : pos_q;
  assign pos_end = PosPayload + {1'b0, len_q};
  assign bad_sum = (xor_q != byte_i);

  always_comb begin
    pos_d       = pos_q;
    xor_d       = xor_q;
    len_d       = len_q;
    cmd_d       = cmd_q;
    err_d       = err_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    res_o.kind  = KindPayload;
    if (pos_eff == PosStart) begin
      xor_d = byte_i;
      err_d = {1'b0, byte_i != cfg_i.start_marker};
      len_d = '0;
      cmd_d = '0;
      pos_d = PosLength;
    end else if (pos_eff == PosLength) begin
      len_d    = byte_i;
      err_d[1] = err_q[1] | (byte_i > cfg_i.max_payload);
      xor_d    = xor_q ^ byte_i;
      pos_d    = PosCmdHi;
    end else if (pos_eff == PosCmdHi) begin
      cmd_d = {byte_i, 8'h00};
      xor_d = xor_q ^ byte_i;
      pos_d = PosCmdLo;
    end else if (pos_eff == PosCmdLo) begin
      cmd_d = {cmd_q[CmdW-1:ByteW], byte_i};
      xor_d = xor_q ^ byte_i;
      pos_d = PosPayload;
    end else if (pos_eff < pos_end) begin
      xor_d              = xor_q ^ byte_i;
      pos_d              = pos_q + pos_t'(1);
      // oversized frames are swallowed up to their checksum
      res_valid_o        = !err_q[1];
      res_o.kind         = KindPayload;
      res_o.command      = cmd_q;
      res_o.payload_byte = byte_i;
      res_o.byte_index   = byte_t'(pos_q - PosPayload);
    end else if (pos_eff == pos_end) begin
      pos_d               = pos_end + pos_t'(1);
      res_valid_o         = 1'b1;
      res_o.kind          = KindStatus;
      res_o.command       = cmd_q;
      res_o.bad_start     = err_q[0];
      res_o.bad_length    = err_q[1];
      res_o.bad_checksum  = bad_sum;
      res_o.frame_invalid = err_q[0] | err_q[1] | bad_sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      xor_q <= '0;
      len_q <= '0;
      cmd_q <= '0;
      err_q <= '0;
    end else if (step_i) begin
      pos_q <= pos_d;
      xor_q <= xor_d;
      len_q <= len_d;
      cmd_q <= cmd_d;
      err_q <= err_d;
    end
  end

  `XCFD_ASSERT_IMP(a_pos_bounded, clk_i, rst_ni, 1'b1, pos_q <= PosMax)
  `XCFD_ASSERT_NXT(a_payload_advances, clk_i, rst_ni,
                   step_i && !first_i && pos_q >= PosPayload && pos_q < pos_end,
                   pos_q == $past(pos_q) + pos_t'(1))

endmodule

// ----- hw/rtl/xor_checked_frame_decoder.sv -----
// channel   dir  handshake                     contents
// s_axis    in   s_axis_tvalid/s_axis_tready   received frame byte, first-byte flag
// m_axis    out  m_axis_tvalid/m_axis_tready   payload word or end-of-frame status
// cfg       in   cfg_valid_i/cfg_ready_o       register index and write data
//
// one byte per cycle sustained unless an output stall holds the input; a byte is registered
// at the input and its result is then registered in the output register
// the parser state advances once per byte through combinational xor/compare logic
// an output stall only holds the input when the waiting byte would make a result
// cfg_ready_o is always high; reset clears frame state and restores the registers
`include "xor_checked_frame_decoder_assert.svh"

module xor_checked_frame_decoder
  import xcfd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] rx_byte
  input  logic        s_axis_tuser,  // [0] frame_first
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [15:0] command, [23:16] payload_byte, [31:24] byte_index, [32] bad_start,
  // [33] bad_length, [34] bad_checksum, [35] frame_invalid, [39:36] zero
  output logic [39:0] m_axis_tdata,
  output logic        m_axis_tuser,  // [0] kind
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  cfg_idx_t    cfg_index_i,
  input  byte_t       cfg_data_i
);

  cfg_t  cfg_q;
  logic  in_valid_q;
  byte_t in_byte_q;
  logic  in_first_q;
  logic  out_valid_q;
  res_t  res_q;

  logic  res_valid;
  res_t  res;
  logic  out_free;
  logic  proc;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_marker <= StartMarkerRst;
      cfg_q.max_payload  <= MaxPayloadRst;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CfgStartMarker) begin
        cfg_q.start_marker <= cfg_data_i;
      end else if (cfg_index_i == CfgMaxPayload) begin
        cfg_q.max_payload <= cfg_data_i;
      end
    end
  end

  assign out_free      = !out_valid_q || m_axis_tready;
  assign proc          = in_valid_q && (!res_valid || out_free);
  assign s_axis_tready = !in_valid_q || proc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q  <= s_axis_tdata;
      in_first_q <= s_axis_tuser;
    end
  end

  xcfd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (proc),
    .byte_i      (in_byte_q),
    .first_i     (in_first_q),
    .cfg_i       (cfg_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (proc && res_valid) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc && res_valid) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = res_q.kind;
  assign m_axis_tdata  = {4'b0000, res_q.frame_invalid, res_q.bad_checksum,
                          res_q.bad_length, res_q.bad_start, res_q.byte_index,
                          res_q.payload_byte, res_q.command};

  // the input side only waits on a full, stalled output word
  `XCFD_ASSERT_IMP(a_in_stall_cause, clk_i, rst_ni,
                   in_valid_q && !s_axis_tready, out_valid_q && !m_axis_tready)
  `XCFD_ASSERT_IMP(a_status_or, clk_i, rst_ni, out_valid_q && res_q.kind == KindStatus,
                   res_q.frame_invalid ==
                   (res_q.bad_start | res_q.bad_length | res_q.bad_checksum))
  `XCFD_ASSERT_IMP(a_payload_clean, clk_i, rst_ni, out_valid_q && res_q.kind == KindPayload,
                   !res_q.bad_start && !res_q.bad_length && !res_q.bad_checksum &&
                   !res_q.frame_invalid)

endmodule
